// ----- rtl/ottt_pkg.sv -----
// Shared types and constants of the one-time token table.
`default_nettype none

package ottt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int STAMP_W = 32;
  localparam int HANDLE_W = 32;
  localparam int TOKEN_W = 64;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W = TOKEN_W + HANDLE_W;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_REGISTERED = 2'd0,
    STATUS_MATCHED    = 2'd1,
    STATUS_NOT_FOUND  = 2'd2,
    STATUS_FULL       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REG,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic accept;
    logic reg_exec;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/ottt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ottt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/ottt_ctrl.sv -----
// Control state machine that sequences register, scan and result beats.
`default_nettype none

module ottt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          action_i,
  output logic               in_ready_o,
  input  wire ottt_pkg::sts_t sts_i,
  output ottt_pkg::cmd_t     cmd_o
);

  import ottt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = action_i ? ST_SCAN : ST_REG;
        end
      end
      ST_REG: begin
        cmd_o.reg_exec = 1'b1;
        state_d = ST_RESP;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ottt_dp.sv -----
// Datapath: entry storage, valid bits, issue counter, scan pipeline and result register.
`default_nettype none

module ottt_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ottt_pkg::cmd_t                cmd_i,
  output ottt_pkg::sts_t                     sts_o,
  input  wire logic [ottt_pkg::STAMP_W-1:0]  timestamp_i,
  input  wire logic [ottt_pkg::HANDLE_W-1:0] context_handle_i,
  input  wire logic [ottt_pkg::TOKEN_W-1:0]  lookup_token_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ottt_pkg::STATUS_W-1:0]      status_o,
  output logic [ottt_pkg::TOKEN_W-1:0]       issued_token_o,
  output logic [ottt_pkg::HANDLE_W-1:0]      found_handle_o
);

  import ottt_pkg::*;

  logic [STAMP_W-1:0]       stamp_q;
  logic [HANDLE_W-1:0]      handle_q;
  logic [TOKEN_W-1:0]       lookup_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [31:0]              counter_q;
  logic [CNT_W-1:0]         scan_idx_q;
  logic                     cmp_vld_q;
  logic [IDX_W-1:0]         cmp_idx_q;

  status_e                  res_status_q;
  logic [TOKEN_W-1:0]       res_token_q;
  logic [HANDLE_W-1:0]      res_handle_q;

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [TOKEN_W-1:0]       out_token_q;
  logic [HANDLE_W-1:0]      out_handle_q;

  logic                     any_free;
  logic [IDX_W-1:0]         free_idx;
  logic [TOKEN_W-1:0]       new_token;
  logic [ENTRY_W-1:0]       rd_data;
  logic                     scan_issue;
  logic                     hit;
  logic                     last;
  logic                     ram_we;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign new_token = {stamp_q, counter_q};
  assign ram_we = cmd_i.reg_exec && any_free;
  assign scan_issue = scan_idx_q != CNT_W'(TABLE_ENTRIES);

  ottt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx),
    .wdata_i({new_token, handle_q}),
    .raddr_i(scan_idx_q[IDX_W-1:0]),
    .rdata_o(rd_data)
  );

  assign hit = cmp_vld_q && valid_q[cmp_idx_q] &&
               (rd_data[ENTRY_W-1:HANDLE_W] == lookup_q);
  assign last = cmp_vld_q && (cmp_idx_q == IDX_W'(TABLE_ENTRIES - 1));

  assign sts_o.scan_done = hit || last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      stamp_q <= timestamp_i;
      handle_q <= context_handle_i;
      lookup_q <= lookup_token_i;
    end
    if (cmd_i.scan_step) begin
      cmp_idx_q <= scan_idx_q[IDX_W-1:0];
    end
    if (cmd_i.reg_exec) begin
      res_handle_q <= '0;
      if (any_free) begin
        res_status_q <= STATUS_REGISTERED;
        res_token_q <= new_token;
      end else begin
        res_status_q <= STATUS_FULL;
        res_token_q <= '0;
      end
    end else if (cmd_i.scan_step && (hit || last)) begin
      res_token_q <= '0;
      if (hit) begin
        res_status_q <= STATUS_MATCHED;
        res_handle_q <= rd_data[HANDLE_W-1:0];
      end else begin
        res_status_q <= STATUS_NOT_FOUND;
        res_handle_q <= '0;
      end
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_token_q <= res_token_q;
      out_handle_q <= res_handle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      counter_q <= '0;
      scan_idx_q <= '0;
      cmp_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[free_idx] <= 1'b1;
        counter_q <= counter_q + 32'd1;
      end else if (cmd_i.scan_step && hit) begin
        valid_q[cmp_idx_q] <= 1'b0;
      end
      if (cmd_i.accept) begin
        scan_idx_q <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_vld_q <= scan_issue;
        if (scan_issue) begin
          scan_idx_q <= scan_idx_q + CNT_W'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;
  assign issued_token_o = out_token_q;
  assign found_handle_o = out_handle_q;

  a_reg_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (counter_q == $past(counter_q) + 32'd1) &&
               ($countones(valid_q) == $countones($past(valid_q)) + 1))
    else $error("register did not advance counter and occupancy");

  a_hit_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.scan_step && hit) |=>
      ($countones(valid_q) + 1 == $countones($past(valid_q))))
    else $error("matched entry was not freed");

endmodule

`default_nettype wire

// ----- rtl/one_time_token_table.sv -----
// Top level of the one-time session token table.
//
// Input channel (in_valid_i/in_ready_o) takes one beat per item: action_i 0
// registers a session from timestamp_i and context_handle_i, action_i 1
// matches and removes lookup_token_i. Each item yields exactly one beat on
// the output channel (out_valid_o/out_ready_i) with status, token and handle.
// Items are handled one at a time; in_ready_o is high only while idle.
// A register beat passes through ST_REG and ST_RESP before out_valid_o rises.
// A match scans the stored entries one per cycle through the entry RAM read
// port and stops at the first hit; a miss takes the full scan. The next beat
// is accepted once the result is loaded and the control is back in ST_IDLE.
// A result waits in the output register while the receiver stalls; the next
// item may be accepted then, and its result is held back until the waiting
// beat is taken.
// Reset clears all valid bits, the issue counter and both channels; entry
// contents are not cleared, as an entry is read only while it is valid.
`default_nettype none

module one_time_token_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          action_i,
  input  wire logic [ottt_pkg::STAMP_W-1:0]  timestamp_i,
  input  wire logic [ottt_pkg::HANDLE_W-1:0] context_handle_i,
  input  wire logic [ottt_pkg::TOKEN_W-1:0]  lookup_token_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ottt_pkg::STATUS_W-1:0]      status_o,
  output logic [ottt_pkg::TOKEN_W-1:0]       issued_token_o,
  output logic [ottt_pkg::HANDLE_W-1:0]      found_handle_o
);

  import ottt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ottt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .action_i  (action_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ottt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .timestamp_i     (timestamp_i),
    .context_handle_i(context_handle_i),
    .lookup_token_i  (lookup_token_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .issued_token_o  (issued_token_o),
    .found_handle_o  (found_handle_o)
  );

  a_token_only_on_register: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_REGISTERED)) |-> (issued_token_o == '0))
    else $error("token reported without a registration");

  a_handle_only_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_MATCHED)) |-> (found_handle_o == '0))
    else $error("handle reported without a match");

endmodule

`default_nettype wire
